>>> hdl/btsc_pkg.sv
// Shared types, constants and register codes of the ball tracking steer controller.
package btsc_pkg;

  localparam int COORD_BITS  = 11;
  localparam int FRAC_BITS   = 6;
  localparam int GOAL_BITS   = COORD_BITS + FRAC_BITS;
  localparam int LIN_BITS    = 12;
  localparam int ANG_BITS    = 16;
  localparam int RATE_BITS   = 15;
  localparam int GAIN_BITS   = 16;
  localparam int MISS_BITS   = 8;
  localparam int SEARCH_BITS = 10;
  localparam int WEIGHT_BITS = 11;
  localparam int WEIGHT_SHIFT = 10;
  localparam int STEER_SHIFT = FRAC_BITS + 4;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;
  localparam int CMD_DEPTH = 2;

  localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = WEIGHT_BITS'(1 << WEIGHT_SHIFT);

  localparam logic [LIN_BITS-1:0]    FORWARD_SPEED_RST = LIN_BITS'(410);
  localparam logic [RATE_BITS-1:0]   TURN_RATE_RST     = RATE_BITS'(3277);
  localparam logic [GAIN_BITS-1:0]   STEER_GAIN_RST    = GAIN_BITS'(328);
  localparam logic [COORD_BITS-1:0]  CENTER_X_RST      = COORD_BITS'(320);
  localparam logic [MISS_BITS-1:0]   MISS_LIMIT_RST    = MISS_BITS'(40);
  localparam logic [SEARCH_BITS-1:0] SEARCH_LIMIT_RST  = SEARCH_BITS'(100);
  localparam logic [WEIGHT_BITS-1:0] NEW_WEIGHT_RST    = WEIGHT_BITS'(819);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FORWARD_SPEED     = 3'd0,
    CFG_SEARCH_TURN_RATE  = 3'd1,
    CFG_STEER_GAIN        = 3'd2,
    CFG_IMAGE_CENTER_X    = 3'd3,
    CFG_MISS_LIMIT        = 3'd4,
    CFG_SEARCH_LIMIT      = 3'd5,
    CFG_FILTER_NEW_WEIGHT = 3'd6
  } cfg_idx_e;

  typedef enum logic {
    REQ_BALL  = 1'b0,
    REQ_EMPTY = 1'b1
  } req_type_e;

  typedef struct packed {
    logic                  req_type;
    logic [COORD_BITS-1:0] ball_x;
    logic [COORD_BITS-1:0] ball_radius;
    logic                  last_of_frame;
    logic                  obstacle_seen;
  } in_word_t;

  typedef struct packed {
    logic [LIN_BITS-1:0]        linear_vel;
    logic signed [ANG_BITS-1:0] angular_vel;
    logic                       path_request;
    logic                       no_ball;
    logic [GOAL_BITS-1:0]       goal_x;
  } out_word_t;

  typedef struct packed {
    logic [LIN_BITS-1:0]    forward_speed;
    logic [RATE_BITS-1:0]   search_turn_rate;
    logic [GAIN_BITS-1:0]   steer_gain;
    logic [COORD_BITS-1:0]  image_center_x;
    logic [MISS_BITS-1:0]   miss_limit;
    logic [SEARCH_BITS-1:0] search_limit;
    logic [WEIGHT_BITS-1:0] filter_new_weight;
  } cfg_t;

  // One finished frame, handed from the front to the back.
  typedef struct packed {
    logic                  empty;
    logic [COORD_BITS-1:0] best_x;
    logic                  obstacle;
  } frame_cmd_t;

endpackage

>>> hdl/btsc_front.sv
// Front end: accepts detection words and keeps the best ball of the open frame.
module btsc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  btsc_pkg::in_word_t  in_word_i,
  input  logic                cmd_ready_i,
  output logic                cmd_push_o,
  output btsc_pkg::frame_cmd_t cmd_o
);
  import btsc_pkg::*;

  logic                  open_q, open_d;
  logic [COORD_BITS-1:0] best_q, best_d;
  logic [COORD_BITS-1:0] maxr_q, maxr_d;
  logic                  accept;
  logic                  is_empty;
  logic [COORD_BITS-1:0] eff_best, eff_maxr;

  assign in_ready_o = cmd_ready_i;
  assign accept     = in_valid_i && cmd_ready_i;
  assign is_empty   = (in_word_i.req_type == REQ_EMPTY);

  always_comb begin
    // A closed frame restarts from this detection with a zero maximum.
    eff_best = open_q ? best_q : in_word_i.ball_x;
    eff_maxr = open_q ? maxr_q : '0;
    best_d   = best_q;
    maxr_d   = maxr_q;
    open_d   = open_q;
    if (accept) begin
      if (is_empty) begin
        open_d = 1'b0;
      end else begin
        best_d = eff_best;
        maxr_d = eff_maxr;
        if (in_word_i.ball_radius > eff_maxr) begin
          best_d = in_word_i.ball_x;
          maxr_d = in_word_i.ball_radius;
        end
        open_d = !in_word_i.last_of_frame;
      end
    end
  end

  assign cmd_push_o      = accept && (is_empty || in_word_i.last_of_frame);
  assign cmd_o.empty     = is_empty;
  assign cmd_o.best_x    = best_d;
  assign cmd_o.obstacle  = in_word_i.obstacle_seen;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      best_q <= '0;
      maxr_q <= '0;
    end else begin
      open_q <= open_d;
      best_q <= best_d;
      maxr_q <= maxr_d;
    end
  end

endmodule

>>> hdl/btsc_cmd_fifo.sv
// Two-entry queue of finished frames between the front and the back.
module btsc_cmd_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  btsc_pkg::frame_cmd_t push_cmd_i,
  output logic                 ready_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output btsc_pkg::frame_cmd_t head_o
);
  import btsc_pkg::*;

  localparam int PTR_BITS = $clog2(CMD_DEPTH);

  frame_cmd_t            mem_q [CMD_DEPTH];
  logic [PTR_BITS-1:0]   wr_q, rd_q;
  logic [PTR_BITS:0]     cnt_q;

  assign ready_o = (cnt_q != (PTR_BITS+1)'(CMD_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_BITS'(CMD_DEPTH-1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_BITS'(CMD_DEPTH-1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (PTR_BITS+1)'(push_i) - (PTR_BITS+1)'(pop_i);
    end
  end

`ifndef SYNTH
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (ready_o || pop_i))
    else $error("frame queue written while full");
  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("frame queue read while empty");
`endif

endmodule

>>> hdl/btsc_back.sv
// Back end: smooths the goal column, runs miss/search counters and forms velocity words.
module btsc_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  btsc_pkg::cfg_t       cfg_i,
  input  logic                 cmd_valid_i,
  input  btsc_pkg::frame_cmd_t cmd_i,
  output logic                 cmd_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output btsc_pkg::out_word_t  out_word_o
);
  import btsc_pkg::*;

  localparam int MUL_BITS  = WEIGHT_BITS + GOAL_BITS;
  localparam int SUM_BITS  = MUL_BITS + 1;
  localparam int PROD_BITS = GAIN_BITS + GOAL_BITS;
  localparam int RND_BITS  = PROD_BITS + 1;
  localparam int R_BITS    = RND_BITS - STEER_SHIFT;
  localparam logic [R_BITS-1:0] POS_MAX = R_BITS'((1 << (ANG_BITS-1)) - 1);
  localparam logic [R_BITS-1:0] NEG_MAX = R_BITS'(1 << (ANG_BITS-1));

  typedef enum logic [2:0] {
    S_IDLE, S_MUL_NEW, S_MUL_OLD, S_SUM, S_STEER, S_VEL
  } state_e;

  state_e                     state_q;
  frame_cmd_t                 cmd_q;
  logic [MUL_BITS-1:0]        prod_new_q, prod_old_q;
  logic [PROD_BITS-1:0]       prod_steer_q;
  logic [GOAL_BITS-1:0]       smooth_q;
  logic [MISS_BITS-1:0]       miss_q;
  logic [SEARCH_BITS-1:0]     search_q;
  logic                       nb_q, path_q;
  logic [LIN_BITS-1:0]        held_lin_q;
  logic signed [ANG_BITS-1:0] held_ang_q;
  logic                       out_valid_q;
  out_word_t                  out_word_q;

  logic [WEIGHT_BITS-1:0]     w_new, w_old;
  logic [GOAL_BITS-1:0]       nx, target, mag;
  logic [SUM_BITS-1:0]        sum;
  logic [MISS_BITS-1:0]       miss_inc;
  logic                       neg_diff;
  logic [RND_BITS-1:0]        rnd;
  logic [R_BITS-1:0]          r;
  logic signed [ANG_BITS-1:0] steer_ang, spin_ang;
  logic [SEARCH_BITS-1:0]     search_inc;
  logic                       search_hit, out_free;

  always_comb begin
    w_new    = (cfg_i.filter_new_weight > WEIGHT_ONE) ? WEIGHT_ONE : cfg_i.filter_new_weight;
    w_old    = WEIGHT_ONE - w_new;
    nx       = {cmd_q.best_x, {FRAC_BITS{1'b0}}};
    sum      = SUM_BITS'(prod_new_q) + SUM_BITS'(prod_old_q)
             + SUM_BITS'(1 << (WEIGHT_SHIFT-1));
    miss_inc = (miss_q != '1) ? miss_q + 1'b1 : miss_q;

    target   = {cfg_i.image_center_x, {FRAC_BITS{1'b0}}};
    neg_diff = smooth_q < target;
    mag      = neg_diff ? target - smooth_q : smooth_q - target;

    // Round half away from zero on the magnitude, then apply the opposite sign.
    rnd = RND_BITS'(prod_steer_q) + RND_BITS'(1 << (STEER_SHIFT-1));
    r   = rnd[RND_BITS-1:STEER_SHIFT];
    if (neg_diff) begin
      steer_ang = (r > POS_MAX) ? signed'(POS_MAX[ANG_BITS-1:0]) : signed'(r[ANG_BITS-1:0]);
    end else begin
      steer_ang = (r > NEG_MAX) ? signed'(NEG_MAX[ANG_BITS-1:0])
                                : signed'(-r[ANG_BITS-1:0]);
    end
    spin_ang = signed'({1'b0, cfg_i.search_turn_rate});

    search_inc = (search_q != '1) ? search_q + 1'b1 : search_q;
    search_hit = search_inc >= cfg_i.search_limit;
    out_free   = !out_valid_q || out_ready_i;
  end

  assign cmd_pop_o = (state_q == S_IDLE) && cmd_valid_i;

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
    prod_new_q   <= w_new * nx;
    prod_old_q   <= w_old * smooth_q;
    prod_steer_q <= cfg_i.steer_gain * mag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      smooth_q    <= '0;
      miss_q      <= '0;
      search_q    <= '0;
      nb_q        <= 1'b0;
      path_q      <= 1'b0;
      held_lin_q  <= '0;
      held_ang_q  <= '0;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
    end else begin
      // Load the output register when the velocity stage fires, drop it once taken.
      if (state_q == S_VEL && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            state_q <= cmd_i.empty ? S_SUM : S_MUL_NEW;
          end
        end
        S_MUL_NEW: state_q <= S_MUL_OLD;
        S_MUL_OLD: state_q <= S_SUM;
        S_SUM: begin
          if (cmd_q.empty) begin
            if (miss_inc >= cfg_i.miss_limit) begin
              miss_q <= cfg_i.miss_limit;
              nb_q   <= 1'b1;
            end else begin
              miss_q <= miss_inc;
            end
          end else begin
            smooth_q <= sum[WEIGHT_SHIFT +: GOAL_BITS];
            miss_q   <= '0;
            search_q <= '0;
            nb_q     <= 1'b0;
            path_q   <= 1'b0;
          end
          state_q <= S_STEER;
        end
        S_STEER: state_q <= S_VEL;
        S_VEL: begin
          if (out_free) begin
            out_word_q.goal_x   <= smooth_q;
            out_word_q.no_ball  <= nb_q;
            if (!nb_q) begin
              out_word_q.path_request <= path_q;
              if (cmd_q.obstacle) begin
                held_lin_q             <= '0;
                held_ang_q             <= spin_ang;
                out_word_q.linear_vel  <= '0;
                out_word_q.angular_vel <= spin_ang;
              end else begin
                held_lin_q             <= cfg_i.forward_speed;
                held_ang_q             <= steer_ang;
                out_word_q.linear_vel  <= cfg_i.forward_speed;
                out_word_q.angular_vel <= steer_ang;
              end
            end else begin
              search_q <= search_hit ? cfg_i.search_limit : search_inc;
              out_word_q.path_request <= path_q || search_hit;
              if (path_q || search_hit) begin
                // Path request: hold the last command.
                path_q                 <= 1'b1;
                out_word_q.linear_vel  <= held_lin_q;
                out_word_q.angular_vel <= held_ang_q;
              end else begin
                held_lin_q             <= '0;
                held_ang_q             <= spin_ang;
                out_word_q.linear_vel  <= '0;
                out_word_q.angular_vel <= spin_ang;
              end
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

`ifndef SYNTH
  a_vel_loads_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_VEL && out_free) |=> (out_valid_q && state_q == S_IDLE))
    else $error("velocity stage did not produce a word");
  a_path_needs_no_ball : assert property (@(posedge clk_i) disable iff (!rst_ni)
    path_q |-> nb_q)
    else $error("path request without no-ball state");
  a_search_needs_no_ball : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (search_q != '0) |-> nb_q)
    else $error("search count running while a ball is tracked");
`endif

endmodule

>>> hdl/ball_tracking_steer_controller.sv
// Top level of the ball tracking steer controller: config registers, front, queue, back.
//
// Input channel (in_valid_i/in_ready_o, in_word_i): one word per ball detection, or one
// word marking a frame with no ball. A detection with last_of_frame closes the frame; an
// empty marker closes it too and drops any pending detections.
// Output channel (out_valid_o/out_ready_i, out_word_o): one velocity word per closed
// frame, none for detections inside a frame.
// Config port (cfg_we_i, cfg_idx_i, cfg_data_i): write one register per cycle, only
// while no frame is in flight. Unknown indexes are ignored.
//
// Throughput: a detection that does not close a frame waits only while the queue is full.
// Frame ends pass through a two-entry queue into a sequencer that takes one frame at a time
// and steps a ball frame through two weight multiplies, the sum, the steering multiply and
// the velocity stage, an empty frame through the sum, the steering multiply and the velocity
// stage only; that sequencer sets the sustained rate of frame ends.
// Stall: a finished word waits in the output register; the back holds its velocity
// stage until the register is free, the queue fills, and then in_ready_o drops.
// Reset: the config registers take their documented reset values, the frame is closed, the
// smoothed column, counters, flags and held velocities are zero.
module ball_tracking_steer_controller (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [btsc_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [btsc_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  btsc_pkg::in_word_t                   in_word_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output btsc_pkg::out_word_t                  out_word_o
);
  import btsc_pkg::*;

  cfg_t       cfg_q;
  logic       cmd_push, cmd_ready, cmd_pop, cmd_valid;
  frame_cmd_t push_cmd, head_cmd;

  // Register file: truncate write data to each register's width.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.forward_speed     <= FORWARD_SPEED_RST;
      cfg_q.search_turn_rate  <= TURN_RATE_RST;
      cfg_q.steer_gain        <= STEER_GAIN_RST;
      cfg_q.image_center_x    <= CENTER_X_RST;
      cfg_q.miss_limit        <= MISS_LIMIT_RST;
      cfg_q.search_limit      <= SEARCH_LIMIT_RST;
      cfg_q.filter_new_weight <= NEW_WEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_FORWARD_SPEED:     cfg_q.forward_speed     <= cfg_data_i[LIN_BITS-1:0];
        CFG_SEARCH_TURN_RATE:  cfg_q.search_turn_rate  <= cfg_data_i[RATE_BITS-1:0];
        CFG_STEER_GAIN:        cfg_q.steer_gain        <= cfg_data_i[GAIN_BITS-1:0];
        CFG_IMAGE_CENTER_X:    cfg_q.image_center_x    <= cfg_data_i[COORD_BITS-1:0];
        CFG_MISS_LIMIT:        cfg_q.miss_limit        <= cfg_data_i[MISS_BITS-1:0];
        CFG_SEARCH_LIMIT:      cfg_q.search_limit      <= cfg_data_i[SEARCH_BITS-1:0];
        CFG_FILTER_NEW_WEIGHT: cfg_q.filter_new_weight <= cfg_data_i[WEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Track the best ball of the open frame; push a frame record at frame end.
  btsc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .cmd_ready_i (cmd_ready),
    .cmd_push_o  (cmd_push),
    .cmd_o       (push_cmd)
  );

  // Decouple frame capture from the multi-cycle control sequencer.
  btsc_cmd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (cmd_push),
    .push_cmd_i (push_cmd),
    .ready_o    (cmd_ready),
    .pop_i      (cmd_pop),
    .valid_o    (cmd_valid),
    .head_o     (head_cmd)
  );

  // Smooth, count misses and searches, form the velocity word.
  btsc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (head_cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

>>> verif/btsc_velocity_checker.sv
// Checker for the ball tracking steer controller: predicts velocity words and compares them.
module btsc_velocity_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [btsc_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [btsc_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  btsc_pkg::in_word_t                  in_word_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  btsc_pkg::out_word_t                 out_word_i,
  output int                                  fail_count_o,
  output int                                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import btsc_pkg::*;

  cfg_t                       regs;
  logic [GOAL_BITS-1:0]       smooth_x;
  logic [COORD_BITS-1:0]      best_x;
  logic [COORD_BITS-1:0]      max_radius;
  logic                       frame_live;
  logic [MISS_BITS-1:0]       misses;
  logic [SEARCH_BITS-1:0]     searches;
  logic                       lost_flag;
  logic                       plan_flag;
  logic [LIN_BITS-1:0]        hold_lin;
  logic signed [ANG_BITS-1:0] hold_ang;
  out_word_t                  velocity_q[$];
  int                         mismatches;

  // Turn toward the image center; sign opposes the column error, halves round away from zero.
  function automatic logic signed [ANG_BITS-1:0] steer_toward_center();
    logic [GOAL_BITS-1:0] target;
    logic [GOAL_BITS-1:0] mag;
    logic [63:0]          rounded;
    logic                 left_of_center;
    target = GOAL_BITS'(regs.image_center_x) << FRAC_BITS;
    left_of_center = smooth_x < target;
    mag = left_of_center ? target - smooth_x : smooth_x - target;
    rounded = (64'(regs.steer_gain) * 64'(mag) + (64'd1 << (STEER_SHIFT - 1))) >> STEER_SHIFT;
    if (left_of_center) begin
      return (rounded > 64'd32767) ? 16'h7FFF : ANG_BITS'(rounded);
    end
    return (rounded > 64'd32768) ? 16'h8000 : ANG_BITS'(-rounded);
  endfunction

  task automatic predict_word(input in_word_t w);
    logic [63:0] wgt;
    logic [63:0] acc;
    out_word_t   res;
    if (w.req_type == REQ_BALL) begin
      if (!frame_live) begin
        frame_live = 1'b1;
        best_x     = w.ball_x;
        max_radius = '0;
      end
      if (w.ball_radius > max_radius) begin
        max_radius = w.ball_radius;
        best_x     = w.ball_x;
      end
      if (!w.last_of_frame) return;
      wgt = (regs.filter_new_weight > WEIGHT_ONE) ? 64'(WEIGHT_ONE)
                                                  : 64'(regs.filter_new_weight);
      acc = wgt * (64'(best_x) << FRAC_BITS) + (64'(WEIGHT_ONE) - wgt) * 64'(smooth_x)
            + (64'd1 << (WEIGHT_SHIFT - 1));
      smooth_x   = GOAL_BITS'(acc >> WEIGHT_SHIFT);
      frame_live = 1'b0;
      misses     = '0;
      searches   = '0;
      lost_flag  = 1'b0;
      plan_flag  = 1'b0;
    end else begin
      frame_live = 1'b0;
      if (misses != '1) misses = misses + 1'b1;
      if (misses >= regs.miss_limit) begin
        misses    = regs.miss_limit;
        lost_flag = 1'b1;
      end
    end

    if (!lost_flag) begin
      if (w.obstacle_seen) begin
        hold_lin = '0;
        hold_ang = ANG_BITS'(regs.search_turn_rate);
      end else begin
        hold_lin = regs.forward_speed;
        hold_ang = steer_toward_center();
      end
    end else begin
      if (searches != '1) searches = searches + 1'b1;
      if (searches >= regs.search_limit) begin
        searches  = regs.search_limit;
        plan_flag = 1'b1;
      end
      // With a path request pending the last command is held as it is.
      if (!plan_flag) begin
        hold_lin = '0;
        hold_ang = ANG_BITS'(regs.search_turn_rate);
      end
    end

    res.linear_vel   = hold_lin;
    res.angular_vel  = hold_ang;
    res.path_request = plan_flag;
    res.no_ball      = lost_flag;
    res.goal_x       = smooth_x;
    velocity_q = {velocity_q, res};
  endtask

  task automatic check_word(input out_word_t got);
    out_word_t want;
    if (velocity_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected velocity word %h", got);
      return;
    end
    want = velocity_q.pop_front();
    if (got.linear_vel !== want.linear_vel || got.angular_vel !== want.angular_vel ||
        got.path_request !== want.path_request || got.no_ball !== want.no_ball ||
        got.goal_x !== want.goal_x) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch lin %0d/%0d ang %0d/%0d path %0b/%0b nob %0b/%0b goal %0d/%0d",
                 want.linear_vel, got.linear_vel, $signed(want.angular_vel),
                 $signed(got.angular_vel), want.path_request, got.path_request,
                 want.no_ball, got.no_ball, want.goal_x, got.goal_x);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs = '{FORWARD_SPEED_RST, TURN_RATE_RST, STEER_GAIN_RST, CENTER_X_RST,
               MISS_LIMIT_RST, SEARCH_LIMIT_RST, NEW_WEIGHT_RST};
      smooth_x   = '0;
      best_x     = '0;
      max_radius = '0;
      frame_live = 1'b0;
      misses     = '0;
      searches   = '0;
      lost_flag  = 1'b0;
      plan_flag  = 1'b0;
      hold_lin   = '0;
      hold_ang   = '0;
      mismatches = 0;
      velocity_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) check_word(out_word_i);
      if (in_valid_i && in_ready_i) predict_word(in_word_i);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FORWARD_SPEED:     regs.forward_speed     = LIN_BITS'(cfg_data_i);
          CFG_SEARCH_TURN_RATE:  regs.search_turn_rate  = RATE_BITS'(cfg_data_i);
          CFG_STEER_GAIN:        regs.steer_gain        = GAIN_BITS'(cfg_data_i);
          CFG_IMAGE_CENTER_X:    regs.image_center_x    = COORD_BITS'(cfg_data_i);
          CFG_MISS_LIMIT:        regs.miss_limit        = MISS_BITS'(cfg_data_i);
          CFG_SEARCH_LIMIT:      regs.search_limit      = SEARCH_BITS'(cfg_data_i);
          CFG_FILTER_NEW_WEIGHT: regs.filter_new_weight = WEIGHT_BITS'(cfg_data_i);
          default: ;
        endcase
      end
      fail_count_o <= mismatches;
      pending_o    <= velocity_q.size();
    end
  end

endmodule

>>> verif/tb_ball_tracking_steer_controller.sv
// Testbench top of the ball tracking steer controller: drives words and registers, gives the verdict.
module tb_ball_tracking_steer_controller;
  timeunit 1ns;
  timeprecision 1ps;
  import btsc_pkg::*;

  // Far above the slowest legal run of about a thousand words with stalls on both sides.
  localparam int RUN_LIMIT = 200000;

  logic                     clk       = 1'b0;
  logic                     rst_n     = 1'b0;
  logic                     cfg_we    = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data  = '0;
  logic                     in_valid  = 1'b0;
  logic                     in_ready;
  in_word_t                 in_word   = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  out_word_t                out_word;
  int                       fail_count;
  int                       pending;
  int                       cycles    = 0;
  // Set while both sides run without any idle cycles.
  bit                       calm      = 1'b0;

  always #4 clk = ~clk;

  ball_tracking_steer_controller dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word)
  );

  btsc_velocity_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_word_i    (in_word),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_word_i   (out_word),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Stall the velocity side about a quarter of the time, except in calm stretches.
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 27);
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == RUN_LIMIT) begin
      $display("ball_tracking_steer_controller test failed");
      $finish;
    end
  end

  function automatic in_word_t ball(int x, int r, bit last, bit obst);
    in_word_t w;
    w.req_type      = REQ_BALL;
    w.ball_x        = COORD_BITS'(x);
    w.ball_radius   = COORD_BITS'(r);
    w.last_of_frame = last;
    w.obstacle_seen = obst;
    return w;
  endfunction

  // Empty-frame marker; the coordinate fields carry junk that must be ignored.
  function automatic in_word_t no_ball_word(bit obst);
    in_word_t w;
    w.req_type      = REQ_EMPTY;
    w.ball_x        = COORD_BITS'($urandom_range(0, 2047));
    w.ball_radius   = COORD_BITS'($urandom_range(0, 2047));
    w.last_of_frame = 1'($urandom_range(0, 1));
    w.obstacle_seen = obst;
    return w;
  endfunction

  function automatic in_word_t random_detection();
    int r;
    // Bias radii toward zero and small ties so the keep-first rule gets exercised.
    case ($urandom_range(3))
      0:       r = 0;
      1:       r = $urandom_range(0, 3);
      default: r = $urandom_range(0, 2047);
    endcase
    return ball($urandom_range(0, 2047), r, 1'b0, $urandom_range(99) < 25);
  endfunction

  function automatic cfg_t reg_set(int fs, int tr, int g, int cx, int ml, int sl, int fw);
    cfg_t c;
    c.forward_speed     = LIN_BITS'(fs);
    c.search_turn_rate  = RATE_BITS'(tr);
    c.steer_gain        = GAIN_BITS'(g);
    c.image_center_x    = COORD_BITS'(cx);
    c.miss_limit        = MISS_BITS'(ml);
    c.search_limit      = SEARCH_BITS'(sl);
    c.filter_new_weight = WEIGHT_BITS'(fw);
    return c;
  endfunction

  function automatic cfg_t random_regs();
    int g;
    int ml;
    int sl;
    int fw;
    g  = ($urandom_range(1) == 0) ? $urandom_range(0, 2000) : $urandom_range(0, 65535);
    // Small limits most of the time so misses turn into search and path requests.
    ml = ($urandom_range(3) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 6);
    sl = ($urandom_range(3) == 0) ? $urandom_range(1, 1023) : $urandom_range(1, 8);
    fw = ($urandom_range(4) == 0) ? $urandom_range(1025, 2047) : $urandom_range(0, 1024);
    return reg_set($urandom_range(0, 4095), $urandom_range(0, 32767), g,
                   $urandom_range(0, 2047), ml, sl, fw);
  endfunction

  // Offer one word; hold valid and payload until accepted, leave valid high on return.
  task automatic push_word(input in_word_t w);
    while (!calm && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_one(input cfg_idx_e idx, input logic [CFG_DATA_BITS-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic load_regs(input cfg_t c);
    write_one(CFG_FORWARD_SPEED,     CFG_DATA_BITS'(c.forward_speed));
    write_one(CFG_SEARCH_TURN_RATE,  CFG_DATA_BITS'(c.search_turn_rate));
    write_one(CFG_STEER_GAIN,        CFG_DATA_BITS'(c.steer_gain));
    write_one(CFG_IMAGE_CENTER_X,    CFG_DATA_BITS'(c.image_center_x));
    write_one(CFG_MISS_LIMIT,        CFG_DATA_BITS'(c.miss_limit));
    write_one(CFG_SEARCH_LIMIT,      CFG_DATA_BITS'(c.search_limit));
    write_one(CFG_FILTER_NEW_WEIGHT, CFG_DATA_BITS'(c.filter_new_weight));
    cfg_we <= 1'b0;
  endtask

  // Drop valid, wait for every velocity word, then let the sequencer go quiet.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Mostly whole frames with random content; the rest are miss bursts and frames cut short.
  task automatic run_random_phase(input int words);
    int       sent;
    int       pick;
    int       n;
    in_word_t w;
    sent = 0;
    while (sent < words) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++) begin
          w = random_detection();
          w.last_of_frame = (k == n - 1);
          push_word(w);
        end
        sent += n;
      end else if (pick < 85) begin
        n = (pick < 80) ? $urandom_range(1, 6) : $urandom_range(10, 50);
        repeat (n) push_word(no_ball_word($urandom_range(99) < 25));
        sent += n;
      end else begin
        n = $urandom_range(1, 3);
        repeat (n) push_word(random_detection());
        push_word(no_ball_word($urandom_range(0, 1)));
        sent += n + 1;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset register values: field extremes and the frame rules.
    push_word(ball(0, 0, 1'b1, 1'b0));
    push_word(ball(2047, 2047, 1'b1, 1'b0));
    // Equal radius keeps the earlier word, a larger one replaces it; obstacle spins.
    push_word(ball(100, 5, 1'b0, 1'b0));
    push_word(ball(200, 5, 1'b0, 1'b0));
    push_word(ball(300, 9, 1'b1, 1'b1));
    // All radii zero: the first detection is kept.
    push_word(ball(700, 0, 1'b0, 1'b0));
    push_word(ball(800, 0, 1'b1, 1'b0));
    // Empty marker inside an open frame drops the pending detection.
    push_word(ball(50, 3, 1'b0, 1'b0));
    push_word(no_ball_word(1'b0));
    push_word(no_ball_word(1'b1));
    push_word(ball(1500, 2047, 1'b0, 1'b0));
    push_word(ball(10, 2046, 1'b1, 1'b1));
    drain();

    // Upper extremes, zero limits, weight above full scale.
    load_regs(reg_set(4095, 32767, 65535, 2047, 0, 0, 2047));
    push_word(ball(0, 7, 1'b1, 1'b0));
    push_word(ball(2047, 1, 1'b1, 1'b0));
    push_word(no_ball_word(1'b0));
    push_word(no_ball_word(1'b1));
    push_word(ball(1000, 4, 1'b1, 1'b1));
    drain();

    // Lower extremes and the widest limits; zero weight freezes the smoothed column.
    load_regs(reg_set(0, 0, 0, 0, 255, 1023, 0));
    push_word(ball(2047, 2047, 1'b1, 1'b0));
    push_word(no_ball_word(1'b1));
    push_word(ball(5, 1, 1'b1, 1'b1));
    drain();

    // Unit values with full gain: steering saturates negative, then a small positive turn.
    load_regs(reg_set(1, 1, 65535, 1, 1, 1, 1024));
    push_word(ball(2047, 3, 1'b1, 1'b0));
    push_word(ball(0, 3, 1'b1, 1'b0));
    push_word(no_ball_word(1'b0));
    push_word(no_ball_word(1'b0));
    push_word(ball(5, 0, 1'b1, 1'b0));
    drain();

    for (int p = 0; p < 5; p++) begin
      calm = (p == 2);
      load_regs(random_regs());
      run_random_phase(160);
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("ball_tracking_steer_controller test passed");
    end else begin
      $display("ball_tracking_steer_controller test failed");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/btsc_pkg.sv
hdl/btsc_front.sv
hdl/btsc_cmd_fifo.sv
hdl/btsc_back.sv
hdl/ball_tracking_steer_controller.sv
verif/btsc_velocity_checker.sv
verif/tb_ball_tracking_steer_controller.sv
